// ----- design/mtld_pkg.sv -----
// ----------------------------------------------------------------------------
// Teleinfo line decoder package
// Shared widths, CSR indices and the request classes passed front to back.
// ----------------------------------------------------------------------------
package mtld_pkg;

   localparam int DefLineDepth = 64;
   localparam int LabelCount   = 34;
   localparam int CsrIdxW      = 2;
   localparam int CsrDataW     = 7;
   localparam logic [29:0] NumMax = 30'd999999999;

   localparam logic [CsrIdxW-1:0] CSR_SUBSCRIPTION = 2'd0;
   localparam logic [CsrIdxW-1:0] CSR_FRAME_START  = 2'd1;
   localparam logic [CsrIdxW-1:0] CSR_FRAME_END    = 2'd2;
   localparam logic [CsrIdxW-1:0] CSR_LINE_END     = 2'd3;

   typedef enum logic [2:0] {
      OP_POLL,
      OP_START,
      OP_END,
      OP_STORE,
      OP_LINE,
      OP_OVERFLOW,
      OP_IGNORE
   } op_type;

   typedef struct packed {
      logic         line_ok;
      logic [5:0]   label_id;
      logic [29:0]  number_value;
      logic [6:0]   char_value;
      logic [55:0]  text_head;
      logic [27:0]  text_tail;
      logic         frame_present;
      logic         frame_complete;
      logic         overflow;
   } rsp_type;

   // Label text up to 9 characters, char 0 in low bits, plus length and group.
   typedef struct packed {
      logic [62:0] txt;
      logic [3:0]  len;
      logic [2:0]  grp;
   } label_type;

   function automatic logic [62:0] pack_txt(input logic [71:0] s, input int n);
      logic [62:0] r;
      r = '0;
      for (int k = 0; k < 9; k++) begin
         if (k < n) begin
            r[7*k +: 7] = s[8*(n-1-k) +: 7];
         end
      end
      return r;
   endfunction

   function automatic label_type label_at(input logic [5:0] i);
      label_type l;
      case (i)
         6'd0:  l = '{pack_txt("ADCO ", 5), 4'd5, 3'd0};
         6'd1:  l = '{pack_txt("OPTARIF ", 8), 4'd8, 3'd0};
         6'd2:  l = '{pack_txt("ISOUSC ", 7), 4'd7, 3'd0};
         6'd3:  l = '{pack_txt("MOTDETAT ", 9), 4'd9, 3'd0};
         6'd4:  l = '{pack_txt("PTEC ", 5), 4'd5, 3'd0};
         6'd5:  l = '{pack_txt("PAPP ", 5), 4'd5, 3'd0};
         6'd6:  l = '{pack_txt("IINST ", 6), 4'd6, 3'd1};
         6'd7:  l = '{pack_txt("IMAX ", 5), 4'd5, 3'd1};
         6'd8:  l = '{pack_txt("ADPS ", 5), 4'd5, 3'd2};
         6'd9:  l = '{pack_txt("IINST1 ", 7), 4'd7, 3'd2};
         6'd10: l = '{pack_txt("IINST2 ", 7), 4'd7, 3'd2};
         6'd11: l = '{pack_txt("IINST3 ", 7), 4'd7, 3'd2};
         6'd12: l = '{pack_txt("IMAX1 ", 6), 4'd6, 3'd2};
         6'd13: l = '{pack_txt("IMAX2 ", 6), 4'd6, 3'd2};
         6'd14: l = '{pack_txt("IMAX3 ", 6), 4'd6, 3'd2};
         6'd15: l = '{pack_txt("PPOT ", 5), 4'd5, 3'd2};
         6'd16: l = '{pack_txt("PMAX ", 5), 4'd5, 3'd2};
         6'd17: l = '{pack_txt("ADIR1 ", 6), 4'd6, 3'd2};
         6'd18: l = '{pack_txt("ADIR2 ", 6), 4'd6, 3'd2};
         6'd19: l = '{pack_txt("ADIR3 ", 6), 4'd6, 3'd2};
         6'd20: l = '{pack_txt("BASE ", 5), 4'd5, 3'd3};
         6'd21: l = '{pack_txt("HCHC ", 5), 4'd5, 3'd4};
         6'd22: l = '{pack_txt("HCHP ", 5), 4'd5, 3'd4};
         6'd23: l = '{pack_txt("HHPHC ", 6), 4'd6, 3'd4};
         6'd24: l = '{pack_txt("EJPHN ", 6), 4'd6, 3'd5};
         6'd25: l = '{pack_txt("EJPHPM ", 7), 4'd7, 3'd5};
         6'd26: l = '{pack_txt("PEJP ", 5), 4'd5, 3'd5};
         6'd27: l = '{pack_txt("BBRHCJB ", 8), 4'd8, 3'd6};
         6'd28: l = '{pack_txt("BBRHPJB ", 8), 4'd8, 3'd6};
         6'd29: l = '{pack_txt("BBRHCJW ", 8), 4'd8, 3'd6};
         6'd30: l = '{pack_txt("BBRHPJW ", 8), 4'd8, 3'd6};
         6'd31: l = '{pack_txt("BBRHCJR ", 8), 4'd8, 3'd6};
         6'd32: l = '{pack_txt("BBRHPJR ", 8), 4'd8, 3'd6};
         6'd33: l = '{pack_txt("DEMAIN ", 7), 4'd7, 3'd6};
         default: l = '{63'd0, 4'd15, 3'd7};
      endcase
      return l;
   endfunction

   function automatic logic group_on(input logic [2:0] grp, input logic [3:0] sub);
      logic r;
      case (grp)
         3'd0: r = 1'b1;
         3'd1: r = (sub <= 4'd4);
         3'd2: r = (sub >= 4'd5);
         3'd3, 3'd4, 3'd5, 3'd6: r = (sub == {1'b0, grp} - 4'd2);
         default: r = 1'b0;
      endcase
      return r;
   endfunction

endpackage

// ----- design/mtld_stream_if.sv -----
// ----------------------------------------------------------------------------
// Valid/ready stream interface
// Carries one payload of type T with a source and a sink view.
// ----------------------------------------------------------------------------
interface mtld_stream_if #(parameter type T = logic);
   logic valid;
   logic ready;
   T     data;
   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

// ----- design/meter_teleinfo_line_decoder_core.sv -----
// ----------------------------------------------------------------------------
// Teleinfo line decoder core
// Decodes historic-mode meter bytes into checked, labeled lines.
// ----------------------------------------------------------------------------
// One response per request. The front end classifies a byte in its accept
// cycle and writes the line store; a two-entry queue feeds the back end. When
// the back end is idle, a request passes the queue register and then the
// registered response output. A line end of n >= 4 bytes is walked through one
// store read port: the checksum, then its compare, then each label visited with
// its label characters compared, then the value characters. Since the walk
// reads the store, req.ready stays low from the acceptance of a line end until
// its walk is done.
module meter_teleinfo_line_decoder_core
   import mtld_pkg::*;
#(
   parameter int LINE_DEPTH = DefLineDepth
) (
   input  logic                clock,
   input  logic                reset,
   mtld_stream_if.sink         req,
   mtld_stream_if.source       rsp,
   input  logic                csr_we,
   input  logic [CsrIdxW-1:0]  csr_idx,
   input  logic [CsrDataW-1:0] csr_wdata
);
   localparam int LenW = $clog2(LINE_DEPTH + 1);
   localparam int AdrW = $clog2(LINE_DEPTH);
   localparam int QW   = $bits(op_type) + LenW + 2;

   logic [3:0] sub_ff;
   logic [6:0] start_ff, end_ff, lend_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         sub_ff <= 4'd1; start_ff <= 7'd2; end_ff <= 7'd3; lend_ff <= 7'd13;
      end else if (csr_we) begin
         case (csr_idx)
            CSR_SUBSCRIPTION: sub_ff   <= csr_wdata[3:0];
            CSR_FRAME_START:  start_ff <= csr_wdata;
            CSR_FRAME_END:    end_ff   <= csr_wdata;
            CSR_LINE_END:     lend_ff  <= csr_wdata;
            default: ;
         endcase
      end
   end

   logic f_valid, f_ready, f_present, f_complete, wr_en;
   op_type f_op, b_op;
   logic [LenW-1:0] f_len, b_len;
   logic [AdrW-1:0] wr_adr;
   logic [6:0] wr_data;
   logic b_valid, b_ready, b_present, b_complete, b_busy, line_pop;
   logic [QW-1:0] b_word;

   mtld_front #(.LINE_DEPTH(LINE_DEPTH)) u_front (
      .clock, .reset,
      .req_valid(req.valid), .req_ready(req.ready),
      .in_cmd(req.data[8]), .in_byte(req.data[6:0]),
      .start_code(start_ff), .end_code(end_ff), .lend_code(lend_ff),
      .line_pop, .back_busy(b_busy),
      .q_ready(f_ready), .q_valid(f_valid), .q_op(f_op), .q_len(f_len),
      .q_present(f_present), .q_complete(f_complete),
      .wr_en, .wr_adr, .wr_data
   );

   mtld_queue #(.W(QW)) u_queue (
      .clock, .reset,
      .in_valid(f_valid), .in_ready(f_ready),
      .in_data({f_op, f_len, f_present, f_complete}),
      .out_valid(b_valid), .out_ready(b_ready), .out_data(b_word)
   );

   assign {b_op, b_len, b_present, b_complete} = b_word;
   assign line_pop = b_valid && b_ready && (b_op == OP_LINE);

   mtld_back #(.LINE_DEPTH(LINE_DEPTH)) u_back (
      .clock, .reset, .subscription(sub_ff),
      .q_valid(b_valid), .q_ready(b_ready), .q_op(b_op), .q_len(b_len),
      .q_present(b_present), .q_complete(b_complete),
      .wr_en, .wr_adr, .wr_data, .busy(b_busy),
      .rsp_valid(rsp.valid), .rsp_ready(rsp.ready), .rsp_data(rsp.data)
   );
endmodule

// ----- design/mtld_front.sv -----
// ----------------------------------------------------------------------------
// Teleinfo front end
// Classifies each request, keeps frame flags and fills the line store.
// ----------------------------------------------------------------------------
module mtld_front
   import mtld_pkg::*;
#(
   parameter int LINE_DEPTH = DefLineDepth,
   localparam int LenW = $clog2(LINE_DEPTH + 1),
   localparam int AdrW = $clog2(LINE_DEPTH)
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_ready,
   input  logic            in_cmd,
   input  logic [6:0]      in_byte,
   input  logic [6:0]      start_code,
   input  logic [6:0]      end_code,
   input  logic [6:0]      lend_code,
   input  logic            line_pop,
   input  logic            back_busy,
   input  logic            q_ready,
   output logic            q_valid,
   output op_type          q_op,
   output logic [LenW-1:0] q_len,
   output logic            q_present,
   output logic            q_complete,
   output logic            wr_en,
   output logic [AdrW-1:0] wr_adr,
   output logic [6:0]      wr_data
);
   logic [LenW-1:0] len_ff, len_in;
   logic in_frame_ff, in_frame_in, present_ff, present_in, complete_ff, complete_in;
   logic line_pend_ff;
   op_type op;

   // hold off new requests while the queue is full, or while a line end waits in the queue or is walked
   assign req_ready = q_ready && !line_pend_ff && !back_busy;
   wire take = req_valid && req_ready;

   always_comb begin
      len_in = len_ff; in_frame_in = in_frame_ff;
      present_in = present_ff; complete_in = complete_ff;
      op = OP_IGNORE;
      if (in_cmd) begin
         op = OP_POLL; present_in = 1'b0; complete_in = 1'b0;
      end else if (in_byte == start_code) begin
         op = OP_START; len_in = '0; in_frame_in = 1'b1; present_in = 1'b1;
      end else if (in_byte == end_code) begin
         op = OP_END;
         if (in_frame_ff) complete_in = 1'b1;
      end else if (in_frame_ff) begin
         if (len_ff >= LenW'(LINE_DEPTH)) begin
            op = OP_OVERFLOW; len_in = '0; in_frame_in = 1'b0; present_in = 1'b0;
         end else if (in_byte == lend_code) begin
            op = OP_LINE; len_in = '0;
         end else begin
            op = OP_STORE; len_in = len_ff + 1'b1;
         end
      end
   end

   assign q_valid    = take;
   assign q_op       = op;
   assign q_len      = len_ff + 1'b1;
   assign q_present  = present_in;
   assign q_complete = complete_in;
   assign wr_en      = take && (op == OP_STORE || op == OP_LINE);
   assign wr_adr     = len_ff[AdrW-1:0];
   assign wr_data    = in_byte;

   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff <= '0; in_frame_ff <= 1'b0; present_ff <= 1'b0; complete_ff <= 1'b0;
      end else if (take) begin
         len_ff <= len_in; in_frame_ff <= in_frame_in;
         present_ff <= present_in; complete_ff <= complete_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         line_pend_ff <= 1'b0;
      end else if (line_pop) begin
         line_pend_ff <= 1'b0;
      end else if (take && op == OP_LINE) begin
         line_pend_ff <= 1'b1;
      end
   end
endmodule

// ----- design/mtld_back.sv -----
// ----------------------------------------------------------------------------
// Teleinfo back end
// Takes queued requests; at a line end walks the store for checksum, labels
// and value, and takes no new request until the walk is done.
// ----------------------------------------------------------------------------
module mtld_back
   import mtld_pkg::*;
#(
   parameter int LINE_DEPTH = DefLineDepth,
   localparam int LenW = $clog2(LINE_DEPTH + 1),
   localparam int AdrW = $clog2(LINE_DEPTH)
) (
   input  logic            clock,
   input  logic            reset,
   input  logic [3:0]      subscription,
   input  logic            q_valid,
   output logic            q_ready,
   input  op_type          q_op,
   input  logic [LenW-1:0] q_len,
   input  logic            q_present,
   input  logic            q_complete,
   input  logic            wr_en,
   input  logic [AdrW-1:0] wr_adr,
   input  logic [6:0]      wr_data,
   output logic            busy,
   output logic            rsp_valid,
   input  logic            rsp_ready,
   output rsp_type         rsp_data
);
   typedef enum logic [3:0] {
      S_IDLE, S_SUM_RD, S_SUM, S_CHK, S_LBL, S_LBL_RD, S_LBL_CMP, S_VAL_RD, S_VAL,
      S_OUT
   } state_type;

   logic [6:0] mem [LINE_DEPTH];
   logic [6:0] rd_ff;
   logic [AdrW-1:0] rd_adr;

   state_type  state_ff;
   rsp_type    rsp_ff;
   logic       rsp_valid_ff, rsp_valid_in;
   logic [LenW-1:0] n_ff, k_ff, vlen_ff;
   logic [5:0] sum_ff, lbl_ff;
   logic [3:0] pos_ff;
   logic       digits_ff;
   label_type  lb;

   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_adr] <= wr_data;
      rd_ff <= mem[rd_adr];
   end

   assign lb = label_at(lbl_ff);

   always_comb begin
      case (state_ff)
         S_LBL_RD, S_LBL_CMP: rd_adr = AdrW'(4'd1 + pos_ff);
         default:             rd_adr = k_ff[AdrW-1:0];
      endcase
   end

   assign q_ready   = (state_ff == S_IDLE) && (!rsp_valid_ff || rsp_ready);
   assign busy      = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   wire [LenW:0] lbl_fit = LenW'(lb.len) + 3;
   wire [4:0] dg = {1'b0, rd_ff[3:0]};
   wire is_dig = rd_ff >= 7'h30 && rd_ff <= 7'h39;
   wire [33:0] num_x10 = {rsp_ff.number_value, 3'b0} + {rsp_ff.number_value, 1'b0}
                         + 34'(dg);
   wire [LenW-1:0] vi = k_ff - (LenW'(lb.len) + 1'b1);
   wire accept = q_valid && q_ready;
   wire walk = (q_op == OP_LINE) && (q_len >= LenW'(4));
   wire chk_wait = (k_ff == n_ff - 2'd2);
   wire sum_ok = ({1'b0, sum_ff} + 7'h20) == rd_ff;

   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      case (state_ff)
         S_IDLE:  if (accept && !walk) rsp_valid_in = 1'b1;
         S_CHK:   if (!chk_wait && !sum_ok) rsp_valid_in = 1'b1;
         S_LBL:   if (lbl_ff == 6'(LabelCount)) rsp_valid_in = 1'b1;
         S_OUT:   rsp_valid_in = 1'b1;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE; rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         case (state_ff)
            S_IDLE: begin
               if (accept) begin
                  rsp_ff <= '0;
                  rsp_ff.frame_present  <= q_present;
                  rsp_ff.frame_complete <= q_complete;
                  rsp_ff.overflow       <= (q_op == OP_OVERFLOW);
                  n_ff <= q_len;
                  if (walk) begin
                     k_ff <= LenW'(1); sum_ff <= '0; state_ff <= S_SUM_RD;
                  end
               end
            end
            S_SUM_RD: begin
               // checksum covers store[1 .. n-4], then compare store[n-2]
               if (k_ff + 3 < n_ff) state_ff <= S_SUM;
               else begin
                  k_ff <= n_ff - 2'd2; state_ff <= S_CHK;
               end
            end
            S_SUM: begin
               sum_ff <= sum_ff + rd_ff[5:0];
               k_ff <= k_ff + 1'b1; state_ff <= S_SUM_RD;
            end
            S_CHK: begin
               if (chk_wait) begin
                  k_ff <= '0; // wait for the registered read data
               end else begin
                  if (sum_ok) begin
                     rsp_ff.line_ok <= 1'b1; lbl_ff <= '0; state_ff <= S_LBL;
                  end else begin
                     state_ff <= S_IDLE;
                  end
               end
            end
            S_LBL: begin
               if (lbl_ff == 6'(LabelCount)) begin
                  state_ff <= S_IDLE;
               end else if (!group_on(lb.grp, subscription) || lbl_fit > n_ff) begin
                  lbl_ff <= lbl_ff + 1'b1;
               end else begin
                  pos_ff <= '0; state_ff <= S_LBL_RD;
               end
            end
            S_LBL_RD: state_ff <= S_LBL_CMP;
            S_LBL_CMP: begin
               if (rd_ff != lb.txt[7*pos_ff +: 7]) begin
                  lbl_ff <= lbl_ff + 1'b1; state_ff <= S_LBL;
               end else if (pos_ff + 1'b1 == lb.len) begin
                  rsp_ff.label_id <= lbl_ff + 1'b1;
                  vlen_ff <= n_ff - 2'd3 - (LenW'(lb.len) + 1'b1);
                  k_ff <= LenW'(lb.len) + 1'b1; digits_ff <= 1'b1;
                  state_ff <= S_VAL_RD;
               end else begin
                  pos_ff <= pos_ff + 1'b1; state_ff <= S_LBL_RD;
               end
            end
            S_VAL_RD: begin
               if (vi >= vlen_ff) state_ff <= S_OUT;
               else state_ff <= S_VAL;
            end
            S_VAL: begin
               if (digits_ff && is_dig) begin
                  rsp_ff.number_value <= (num_x10 > 34'(NumMax)) ? NumMax : num_x10[29:0];
               end else digits_ff <= 1'b0;
               if (vi == '0) rsp_ff.char_value <= rd_ff;
               if (vi < LenW'(8)) rsp_ff.text_head[7*vi[2:0] +: 7] <= rd_ff;
               else if (vi < LenW'(12)) rsp_ff.text_tail[7*vi[1:0] +: 7] <= rd_ff;
               k_ff <= k_ff + 1'b1; state_ff <= S_VAL_RD;
            end
            S_OUT: begin
               state_ff <= S_IDLE;
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end
endmodule

// ----- design/mtld_queue.sv -----
// ----------------------------------------------------------------------------
// Request queue
// Two-entry FIFO between front and back end for classified requests.
// ----------------------------------------------------------------------------
module mtld_queue
   import mtld_pkg::*;
#(
   parameter int W = 8
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         in_valid,
   output logic         in_ready,
   input  logic [W-1:0] in_data,
   output logic         out_valid,
   input  logic         out_ready,
   output logic [W-1:0] out_data
);
   logic [W-1:0] q_ff [2];
   logic [1:0]   cnt_ff;
   logic         rp_ff, wp_ff;
   wire push = in_valid && in_ready;
   wire pop  = out_valid && out_ready;

   assign in_ready  = cnt_ff != 2'd2;
   assign out_valid = cnt_ff != 2'd0;
   assign out_data  = q_ff[rp_ff];

   always_ff @(posedge clock) begin
      if (push) q_ff[wp_ff] <= in_data;
      if (reset) begin
         cnt_ff <= '0; rp_ff <= 1'b0; wp_ff <= 1'b0;
      end else begin
         if (push) wp_ff <= ~wp_ff;
         if (pop) rp_ff <= ~rp_ff;
         cnt_ff <= cnt_ff + 2'(push) - 2'(pop);
      end
   end
endmodule

// ----- design/mtld_checker.sv -----
// ----------------------------------------------------------------------------
// Teleinfo decoder port checker
// Port-level properties of the decoder, bound to the top level.
// ----------------------------------------------------------------------------
module mtld_checker
   import mtld_pkg::*;
(
   input logic    clock,
   input logic    reset,
   input logic    rsp_valid,
   input logic    rsp_ready,
   input rsp_type rsp_data
);
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("response dropped while stalled");
   a_label: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.label_id != 6'd0 |-> rsp_data.line_ok)
      else $error("label without good line");
   a_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.label_id <= 6'(LabelCount) && rsp_data.number_value <= NumMax)
      else $error("response field out of range");
   a_ovf: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.overflow |-> !rsp_data.line_ok && !rsp_data.frame_present)
      else $error("overflow response inconsistent");
endmodule

bind meter_teleinfo_line_decoder_core mtld_checker u_chk (
   .clock, .reset, .rsp_valid(rsp.valid), .rsp_ready(rsp.ready), .rsp_data(rsp.data)
);

// ----- sim/meter_teleinfo_line_decoder_core_tb.sv -----
// ----------------------------------------------------------------------------
// Teleinfo line decoder core testbench
// Drives framed meter lines, polls and noise through the request stream,
// predicts every response in a local line decoder and checks it field by
// field. Subscriptions and framing codes change between phases.
// ----------------------------------------------------------------------------
module meter_teleinfo_line_decoder_core_tb;
   import mtld_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic       cmd;
      logic [7:0] rx_byte;
   } req_type;

   localparam int  WatchLimit = 20000;
   localparam int  StoreDepth = DefLineDepth;
   localparam logic CMD_BYTE  = 1'b0;
   localparam logic CMD_POLL  = 1'b1;
   localparam logic [6:0] LineStartChar = 7'h0A;

   logic clock;
   logic reset;
   logic csr_we;
   logic [CsrIdxW-1:0] csr_idx;
   logic [CsrDataW-1:0] csr_wdata;

   mtld_stream_if #(.T(req_type)) req_if ();
   mtld_stream_if #(.T(rsp_type)) rsp_if ();

   meter_teleinfo_line_decoder_core i_dut (
      .clock    (clock),
      .reset    (reset),
      .req      (req_if),
      .rsp      (rsp_if),
      .csr_we   (csr_we),
      .csr_idx  (csr_idx),
      .csr_wdata(csr_wdata)
   );

   always begin
      clock = 1'b1;
      #5;
      clock = 1'b0;
      #5;
   end

   // Label table in meter order, with enable groups.
   string label_txt [LabelCount] = '{
      "ADCO ", "OPTARIF ", "ISOUSC ", "MOTDETAT ", "PTEC ", "PAPP ",
      "IINST ", "IMAX ",
      "ADPS ", "IINST1 ", "IINST2 ", "IINST3 ", "IMAX1 ", "IMAX2 ", "IMAX3 ",
      "PPOT ", "PMAX ", "ADIR1 ", "ADIR2 ", "ADIR3 ",
      "BASE ", "HCHC ", "HCHP ", "HHPHC ", "EJPHN ", "EJPHPM ", "PEJP ",
      "BBRHCJB ", "BBRHPJB ", "BBRHCJW ", "BBRHPJW ", "BBRHCJR ", "BBRHPJR ", "DEMAIN "
   };
   int label_grp [LabelCount] = '{
      0, 0, 0, 0, 0, 0, 1, 1, 2, 2, 2, 2, 2, 2, 2, 2, 2, 2, 2, 2,
      3, 4, 4, 4, 5, 5, 5, 6, 6, 6, 6, 6, 6, 6
   };

   // Decoder state mirror.
   logic [3:0] sub_mode;
   logic [6:0] start_code, end_code, eol_code;
   logic [6:0] line_buf [StoreDepth];
   int         line_len;
   bit         in_frame, frame_done, present, complete;

   req_type pending [$];
   rsp_type expected_rsp [$];
   bit      failed;
   bit      req_taken, rsp_taken;
   int      req_gap, rsp_stall, req_burst, rsp_burst;
   int      quiet_cycles;

   function automatic bit label_enabled(int grp, logic [3:0] sub);
      case (grp)
         0: return 1'b1;
         1: return sub <= 4'd4;
         2: return sub >= 4'd5;
         default: return int'(sub) == grp - 2;
      endcase
   endfunction

   task automatic decode_line(input int n, inout rsp_type e);
      int lbl, width, vstart, vlen;
      bit hit, digits;
      longint num;
      logic [6:0] c;
      for (lbl = 0; lbl < LabelCount; lbl++) begin
         width = label_txt[lbl].len();
         if (!label_enabled(label_grp[lbl], sub_mode) || width + 3 > n) continue;
         hit = 1'b1;
         for (int k = 0; k < width; k++)
            if ({1'b0, line_buf[1+k]} != label_txt[lbl][k]) hit = 1'b0;
         if (!hit) continue;
         vstart = 1 + width;
         vlen = n - 3 - vstart;
         num = 0;
         digits = 1'b1;
         for (int k = 0; k < vlen; k++) begin
            c = line_buf[vstart+k];
            if (digits && c >= 7'h30 && c <= 7'h39) begin
               if (num > (longint'(NumMax) - (c - 7'h30)) / 10) num = NumMax;
               else num = num * 10 + (c - 7'h30);
            end else begin
               digits = 1'b0;
            end
            if (k < 8) e.text_head[7*k +: 7] = c;
            else if (k < 12) e.text_tail[7*(k-8) +: 7] = c;
         end
         e.label_id = lbl + 1;
         e.number_value = num[29:0];
         e.char_value = (vlen > 0) ? line_buf[vstart] : 7'd0;
         return;
      end
   endtask

   task automatic predict_response(input req_type r, output rsp_type e);
      logic [6:0] b;
      int sum;
      e = '0;
      b = r.rx_byte[6:0];
      if (r.cmd == CMD_POLL) begin
         present = 1'b0;
         complete = 1'b0;
      end else if (b == start_code) begin
         line_len = 0;
         in_frame = 1'b1;
         frame_done = 1'b0;
         present = 1'b1;
      end else if (b == end_code) begin
         if (in_frame) begin
            frame_done = 1'b1;
            complete = 1'b1;
         end
      end else if (in_frame) begin
         if (line_len >= StoreDepth) begin
            e.overflow = 1'b1;
            line_len = 0;
            in_frame = 1'b0;
            frame_done = 1'b0;
            present = 1'b0;
         end else begin
            line_buf[line_len] = b;
            line_len++;
            if (b == eol_code) begin
               if (line_len >= 4) begin
                  sum = 0;
                  for (int k = 1; k + 3 < line_len; k++) sum += line_buf[k];
                  if ((sum & 'h3F) + 'h20 == line_buf[line_len-2]) begin
                     e.line_ok = 1'b1;
                     decode_line(line_len, e);
                  end
               end
               line_len = 0;
            end
         end
      end
      e.frame_present = present;
      e.frame_complete = complete;
   endtask

   task automatic check_field(string name, longint unsigned want, longint unsigned got);
      if (want != got) begin
         $error("%s: expected %0h, got %0h", name, want, got);
         failed = 1'b1;
      end
   endtask

   // Accept requests, check responses, watch for a stalled run.
   always @(posedge clock) begin : mon
      rsp_type e;
      if (!reset) begin
         if (req_if.valid && req_if.ready) begin
            predict_response(req_if.data, e);
            expected_rsp.push_back(e);
            void'(pending.pop_front());
            req_taken = 1'b1;
            quiet_cycles = 0;
         end
         if (rsp_if.valid && rsp_if.ready) begin
            quiet_cycles = 0;
            rsp_taken = 1'b1;
            if (expected_rsp.size() == 0) begin
               $error("response with no request outstanding");
               failed = 1'b1;
            end else begin
               e = expected_rsp.pop_front();
               check_field("line_ok", e.line_ok, rsp_if.data.line_ok);
               check_field("label_id", e.label_id, rsp_if.data.label_id);
               check_field("number_value", e.number_value, rsp_if.data.number_value);
               check_field("char_value", e.char_value, rsp_if.data.char_value);
               check_field("text_head", e.text_head, rsp_if.data.text_head);
               check_field("text_tail", e.text_tail, rsp_if.data.text_tail);
               check_field("frame_present", e.frame_present, rsp_if.data.frame_present);
               check_field("frame_complete", e.frame_complete, rsp_if.data.frame_complete);
               check_field("overflow", e.overflow, rsp_if.data.overflow);
            end
         end
         quiet_cycles++;
         if (quiet_cycles >= WatchLimit) begin
            $display("[meter_teleinfo_line_decoder_core] ERROR");
            $finish;
         end
      end
   end

   function automatic int draw_wait(inout int burst);
      if (burst > 0) begin
         burst--;
         return 0;
      end
      if ($urandom_range(0, 40) == 0) begin
         burst = $urandom_range(10, 40);
         return 0;
      end
      return $urandom_range(0, 14);
   endfunction

   always @(negedge clock) begin : drv
      logic    nv;
      req_type nd;
      logic    nr;
      nv = req_if.valid;
      nd = req_if.data;
      nr = rsp_if.ready;
      if (reset) begin
         nv = 1'b0;
         nr = 1'b0;
      end else begin
         if (req_taken) begin
            nv = 1'b0;
            req_taken = 1'b0;
            req_gap = draw_wait(req_burst);
         end
         if (!nv) begin
            if (req_gap > 0) req_gap--;
            else if (pending.size() > 0) begin
               nv = 1'b1;
               nd = pending[0];
            end
         end
         if (rsp_taken) begin
            rsp_taken = 1'b0;
            rsp_stall = draw_wait(rsp_burst);
         end
         if (rsp_stall > 0) begin
            nr = 1'b0;
            rsp_stall--;
         end else begin
            nr = 1'b1;
         end
      end
      req_if.valid <= nv;
      req_if.data  <= nd;
      rsp_if.ready <= nr;
   end

   // Stimulus helpers.
   task automatic push_byte(input logic [6:0] b);
      pending.push_back('{CMD_BYTE, {1'($urandom_range(0, 1)), b}});
   endtask

   task automatic push_poll();
      pending.push_back('{CMD_POLL, 8'($urandom_range(0, 255))});
   endtask

   function automatic logic [6:0] pick_char();
      logic [6:0] c;
      do c = 7'($urandom_range(0, 127));
      while (c == start_code || c == end_code || c == eol_code);
      return c;
   endfunction

   function automatic logic [6:0] pick_digit();
      logic [6:0] c;
      do c = 7'h30 + 7'($urandom_range(0, 9));
      while (c == start_code || c == end_code || c == eol_code);
      return c;
   endfunction

   // Line: start char, label, value, separator, checksum, line end.
   task automatic push_line(input int lbl, input logic [6:0] val [$], input bit corrupt);
      int sum;
      logic [7:0] ch;
      sum = 0;
      push_byte(LineStartChar);
      for (int k = 0; k < label_txt[lbl].len(); k++) begin
         ch = label_txt[lbl][k];
         push_byte(ch[6:0]);
         sum += ch[6:0];
      end
      foreach (val[k]) begin
         push_byte(val[k]);
         sum += val[k];
      end
      if (corrupt) sum += $urandom_range(1, 63);
      push_byte(7'h20);
      push_byte(7'((sum & 'h3F) + 'h20));
      push_byte(eol_code);
   endtask

   task automatic make_value(output logic [6:0] val [$]);
      int n;
      val = {};
      case ($urandom_range(0, 5))
         0, 1, 2: begin
            n = $urandom_range(0, 12);
            repeat (n) val.push_back(pick_digit());
         end
         3: repeat ($urandom_range(10, 12)) val.push_back(pick_digit());
         4: begin
            repeat ($urandom_range(0, 4)) val.push_back(pick_digit());
            repeat ($urandom_range(1, 10)) val.push_back(pick_char());
         end
         default: repeat ($urandom_range(0, 40)) val.push_back(pick_char());
      endcase
   endtask

   task automatic write_csr(input logic [CsrIdxW-1:0] idx, input logic [6:0] v);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_idx   <= idx;
      csr_wdata <= v;
      @(negedge clock);
      csr_we    <= 1'b0;
   endtask

   // Hold until every response is back, then reprogram.
   task automatic set_mode(input logic [3:0] sub, input logic [6:0] fs, fe, le);
      while (pending.size() > 0 || expected_rsp.size() > 0 || req_if.valid)
         @(posedge clock);
      repeat (20) @(posedge clock);
      write_csr(CSR_SUBSCRIPTION, {3'd0, sub});
      write_csr(CSR_FRAME_START, fs);
      write_csr(CSR_FRAME_END, fe);
      write_csr(CSR_LINE_END, le);
      sub_mode = sub;
      start_code = fs;
      end_code = fe;
      eol_code = le;
   endtask

   task automatic random_traffic(input int budget);
      logic [6:0] val [$];
      int stop;
      stop = pending.size() + budget;
      push_byte(start_code);
      while (pending.size() < stop) begin
         case ($urandom_range(0, 19))
            0: push_poll();
            1: push_byte(start_code);
            2: push_byte(end_code);
            3: push_byte(7'($urandom_range(0, 127)));
            4: begin
               make_value(val);
               push_line($urandom_range(0, LabelCount - 1), val, 1'b1);
            end
            5: begin
               push_byte(start_code);
               repeat ($urandom_range(StoreDepth, StoreDepth + 3)) push_byte(pick_char());
            end
            6: begin
               push_byte(LineStartChar);
               push_byte(eol_code);
            end
            default: begin
               make_value(val);
               push_line($urandom_range(0, LabelCount - 1), val, 1'b0);
            end
         endcase
      end
   endtask

   initial begin
      logic [6:0] val [$];
      req_if.valid = 1'b0;
      req_if.data  = '0;
      rsp_if.ready = 1'b0;
      csr_we = 1'b0;
      csr_idx = '0;
      csr_wdata = '0;
      reset = 1'b1;
      failed = 1'b0;
      req_taken = 1'b0;
      rsp_taken = 1'b0;
      req_gap = 0;
      rsp_stall = 0;
      req_burst = 0;
      rsp_burst = 0;
      quiet_cycles = 0;
      sub_mode = 4'd1;
      start_code = 7'd2;
      end_code = 7'd3;
      eol_code = 7'd13;
      line_len = 0;
      in_frame = 1'b0;
      frame_done = 1'b0;
      present = 1'b0;
      complete = 1'b0;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed: ignored bytes, poll, good, corrupt and short lines, frame end, overflow.
      push_byte(7'h00);
      push_byte(eol_code);
      push_poll();
      push_byte(start_code);
      val = {};
      for (int k = 0; k < 12; k++) val.push_back(7'h39);
      push_line(0, val, 1'b0);
      val = {7'h31, 7'h32, 7'h41};
      push_line(6, val, 1'b0);
      push_line(5, val, 1'b1);
      val = {};
      push_line(20, val, 1'b0);
      push_byte(LineStartChar);
      push_byte(7'h7F);
      push_byte(eol_code);
      push_byte(end_code);
      val = {7'h48, 7'h43};
      push_line(4, val, 1'b0);
      push_poll();
      push_byte(start_code);
      repeat (StoreDepth + 1) push_byte(7'h41);
      push_byte(7'h7F);

      set_mode(4'd8, 7'd2, 7'd3, 7'd13);
      random_traffic(130);
      set_mode(4'd0, 7'h00, 7'h7F, 7'h1F);
      random_traffic(130);
      set_mode(4'd15, 7'h7F, 7'h01, 7'h00);
      random_traffic(130);
      set_mode(4'd2, 7'd2, 7'd3, 7'd13);
      random_traffic(130);
      set_mode(4'd3, 7'd4, 7'd4, 7'd4);
      random_traffic(60);
      set_mode(4'd5, 7'd2, 7'd2, 7'd13);
      random_traffic(60);
      set_mode(4'd4, 7'd2, 7'd3, 7'd13);
      random_traffic(130);
      set_mode(4'd6, 7'd2, 7'd3, 7'd10 + 7'd3);
      random_traffic(130);
      set_mode(4'd7, 7'd2, 7'd3, 7'd13);
      random_traffic(130);

      while (pending.size() > 0 || expected_rsp.size() > 0) @(posedge clock);
      repeat (300) @(posedge clock);
      if (!failed) begin
         $display("[meter_teleinfo_line_decoder_core] OK");
      end else begin
         $display("[meter_teleinfo_line_decoder_core] ERROR");
      end
      $finish;
   end

endmodule

// ----- meter_teleinfo_line_decoder_core.f -----
design/mtld_pkg.sv
design/mtld_stream_if.sv
design/mtld_front.sv
design/mtld_back.sv
design/mtld_queue.sv
design/meter_teleinfo_line_decoder_core.sv
design/mtld_checker.sv
sim/meter_teleinfo_line_decoder_core_tb.sv
